### rtl/core/set_frame_builder_crc16_core_assert.svh
// Assertion macros used by the checker of the frame builder.
`ifndef SET_FRAME_BUILDER_CRC16_CORE_ASSERT_SVH
`define SET_FRAME_BUILDER_CRC16_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sfbcrc16_pkg.sv
package sfbcrc16_pkg;

    localparam int FrameLen   = 11;
    localparam int IdxW       = $clog2(FrameLen);
    localparam int QueueDepth = 2;

    typedef logic [IdxW-1:0] idx_t;

    localparam idx_t IDX_START  = IdxW'(0);
    localparam idx_t IDX_LEN    = IdxW'(1);
    localparam idx_t IDX_TYPE   = IdxW'(2);
    localparam idx_t IDX_SUB    = IdxW'(3);
    localparam idx_t IDX_ACCESS = IdxW'(4);
    localparam idx_t IDX_VAL0   = IdxW'(5);
    localparam idx_t IDX_VAL1   = IdxW'(6);
    localparam idx_t IDX_VAL2   = IdxW'(7);
    localparam idx_t IDX_VAL3   = IdxW'(8);
    localparam idx_t IDX_CRC_LO = IdxW'(9);
    localparam idx_t IDX_CRC_HI = IdxW'(10);

    localparam logic [7:0]  START_BYTE  = 8'h55;
    localparam logic [7:0]  LEN_BYTE    = 8'h06;
    localparam logic [7:0]  ACCESS_BYTE = 8'h01;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [7:0]  sub_id;
        logic [7:0]  type_id;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t head;
    } q_head_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/sfbcrc16_queue.sv
module sfbcrc16_queue #(
    parameter int DEPTH = sfbcrc16_pkg::QueueDepth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sfbcrc16_pkg::req_t    in_req,
    output sfbcrc16_pkg::q_head_t q_head,
    input  logic                  pop
);
    import sfbcrc16_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    req_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          do_pop;

    assign in_ready = (count_reg != CW'(DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    assign q_head.valid = (count_reg != '0);
    assign q_head.head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/sfbcrc16_framer.sv
module sfbcrc16_framer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfbcrc16_pkg::q_head_t q_head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);
    import sfbcrc16_pkg::*;

    idx_t        idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        load;
    logic        at_last;
    logic [7:0]  cur_byte;

    assign load    = q_head.valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == IDX_CRC_HI);
    assign pop     = load && at_last;

    always_comb
    begin
        case (idx_reg)
            IDX_START:  cur_byte = START_BYTE;
            IDX_LEN:    cur_byte = LEN_BYTE;
            IDX_TYPE:   cur_byte = q_head.head.type_id;
            IDX_SUB:    cur_byte = q_head.head.sub_id;
            IDX_ACCESS: cur_byte = ACCESS_BYTE;
            IDX_VAL0:   cur_byte = q_head.head.value_bits[7:0];
            IDX_VAL1:   cur_byte = q_head.head.value_bits[15:8];
            IDX_VAL2:   cur_byte = q_head.head.value_bits[23:16];
            IDX_VAL3:   cur_byte = q_head.head.value_bits[31:24];
            IDX_CRC_LO: cur_byte = crc_reg[7:0];
            IDX_CRC_HI: cur_byte = crc_reg[15:8];
            default:    cur_byte = START_BYTE;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = at_last;
            idx_next   = at_last ? IDX_START : idx_reg + 1'b1;
            if (idx_reg == IDX_START)
            begin
                crc_next = CRC_INIT;
            end
            else if (idx_reg inside {[IDX_LEN:IDX_VAL3]})
            begin
                crc_next = crc_feed(crc_reg, cur_byte);
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= IDX_START;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

### rtl/core/set_frame_builder_crc16_core.sv
// Path: a request is first written into the queue; when the framer is idle, it then registers
// the first frame byte from the queue head onto the output.
// Throughput: one frame byte per cycle while m_tready is high; each frame has eleven bytes,
// and the queue holds up to QUEUE_DEPTH (default two) requests, the one being sent included.
// Reset: rst_n clears the queue pointers, the byte counter and the output valid and presets
// the checksum to CRC_INIT at once; queued payload is not cleared.
module set_frame_builder_crc16_core #(
    parameter int QUEUE_DEPTH = sfbcrc16_pkg::QueueDepth
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // type_id [7:0], sub_id [15:8], value_bits [47:16]
    input  logic [$bits(sfbcrc16_pkg::req_t)-1:0] s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // frame_byte [7:0]
    output logic [7:0]                            m_tdata,
    output logic                                  m_tlast
);
    import sfbcrc16_pkg::*;

    req_t    in_req;
    q_head_t q_head;
    logic    pop;

    assign in_req = req_t'(s_tdata);

    sfbcrc16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_head   (q_head),
        .pop      (pop)
    );

    sfbcrc16_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/core/sfbcrc16_checker.sv
`include "set_frame_builder_crc16_core_assert.svh"

module sfbcrc16_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import sfbcrc16_pkg::*;

    idx_t cnt_reg;
    logic xfer;

    assign xfer = m_tvalid && m_tready;

    // Position of the next output transfer within its frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= IDX_START;
        end
        else if (xfer)
        begin
            cnt_reg <= (cnt_reg == IDX_CRC_HI) ? IDX_START : cnt_reg + 1'b1;
        end
    end

    `SFB_ASSERT_NEXT(a_valid_holds, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `SFB_ASSERT_NEXT(a_data_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
    `SFB_ASSERT_SAME(a_last_position, xfer, m_tlast == (cnt_reg == IDX_CRC_HI), "tlast not on the eleventh byte")
    `SFB_ASSERT_SAME(a_start_byte, xfer && (cnt_reg == IDX_START), m_tdata == START_BYTE, "frame does not open with the start byte")
    `SFB_ASSERT_SAME(a_access_byte, xfer && (cnt_reg == IDX_ACCESS), m_tdata == ACCESS_BYTE, "access byte missing")

endmodule

bind set_frame_builder_crc16_core sfbcrc16_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/set_frame_builder_crc16_frame_checker.sv
`timescale 1ns / 100ps

module set_frame_builder_crc16_frame_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // type_id [7:0], sub_id [15:8], value_bits [47:16]
    input  logic [$bits(sfbcrc16_pkg::req_t)-1:0] s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    // frame_byte [7:0]
    input  logic [7:0]                            m_tdata,
    input  logic                                  m_tlast,
    output int                                    error_count,
    output int                                    bytes_due,
    output int                                    frames_done
);

    typedef struct {
        logic [7:0] frame_byte;
        logic       last_byte;
        int         request_no;
        int         position;
    } frame_beat_t;

    frame_beat_t frame_bytes_due[$];
    int          requests_seen;

    // Builds the whole frame for one request and queues its bytes in transmit order.
    function automatic void append_frame(input sfbcrc16_pkg::req_t req, input int request_no);
        logic [7:0]  image [sfbcrc16_pkg::FrameLen];
        logic [15:0] crc;
        logic        feedback;
        frame_beat_t beat;
        image[0] = sfbcrc16_pkg::START_BYTE;
        image[1] = sfbcrc16_pkg::LEN_BYTE;
        image[2] = req.type_id;
        image[3] = req.sub_id;
        image[4] = sfbcrc16_pkg::ACCESS_BYTE;
        image[5] = req.value_bits[7:0];
        image[6] = req.value_bits[15:8];
        image[7] = req.value_bits[23:16];
        image[8] = req.value_bits[31:24];
        // The checksum is shifted in one bit at a time, most significant bit first,
        // over everything between the start byte and the checksum itself.
        crc = sfbcrc16_pkg::CRC_INIT;
        for (int b = 1; b <= 8; b++)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                feedback = crc[15] ^ image[b][k];
                crc = {crc[14:0], 1'b0} ^ (feedback ? sfbcrc16_pkg::CRC_POLY : 16'h0000);
            end
        end
        image[9]  = crc[7:0];
        image[10] = crc[15:8];
        for (int i = 0; i < sfbcrc16_pkg::FrameLen; i++)
        begin
            beat.frame_byte = image[i];
            beat.last_byte  = (i == sfbcrc16_pkg::FrameLen - 1);
            beat.request_no = request_no;
            beat.position   = i;
            frame_bytes_due.push_back(beat);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            frame_bytes_due.delete();
            error_count   = 0;
            frames_done   = 0;
            requests_seen = 0;
            bytes_due    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t ns: unexpected output transfer, expected nothing, actual %02h last %b",
                             $time, m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = frame_bytes_due.pop_front();
                    if (m_tdata !== want.frame_byte)
                    begin
                        $display("%0t ns: request %0d byte %0d: frame_byte expected %02h, actual %02h",
                                 $time, want.request_no, want.position, want.frame_byte, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== want.last_byte)
                    begin
                        $display("%0t ns: request %0d byte %0d: last_byte expected %b, actual %b",
                                 $time, want.request_no, want.position, want.last_byte, m_tlast);
                        error_count++;
                    end
                    if (want.last_byte)
                    begin
                        frames_done++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                append_frame(s_tdata, requests_seen);
                requests_seen++;
            end
            bytes_due <= frame_bytes_due.size();
        end
    end

endmodule

### tb/set_frame_builder_crc16_core_test.sv
`timescale 1ns / 100ps

module set_frame_builder_crc16_core_test;

    localparam int RANDOM_REQUESTS = 120;
    localparam int LONG_HOLD       = 160;
    localparam int CYCLE_LIMIT     = 200000;

    logic                                  clk      = 1'b0;
    logic                                  rst_n    = 1'b0;
    logic                                  s_tvalid = 1'b0;
    logic                                  s_tready;
    logic [$bits(sfbcrc16_pkg::req_t)-1:0] s_tdata  = '0;
    logic                                  m_tvalid;
    logic                                  m_tready = 1'b0;
    logic [7:0]                            m_tdata;
    logic                                  m_tlast;

    int error_count;
    int bytes_due;
    int frames_done;
    int hold_requests  = 0;
    int holds_served   = 0;
    int cycle_count    = 0;
    int directed_sent  = 0;
    int random_sent    = 0;

    set_frame_builder_crc16_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    set_frame_builder_crc16_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .bytes_due   (bytes_due),
        .frames_done (frames_done)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d frame bytes outstanding.",
                     cycle_count, bytes_due);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver alternates between spans of differing readiness and serves
    // any long hold-off that the stimulus asks for.
    initial
    begin : receiver
        int mode;
        int span;
        int period;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holds_served < hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end
            else
            begin
                mode   = $urandom_range(0, 3);
                span   = $urandom_range(4, 48);
                period = $urandom_range(2, 5);
                for (int c = 0; c < span && holds_served >= hold_requests; c++)
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= (c % period == 0);
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic sfbcrc16_pkg::req_t compose(input logic [7:0] type_id,
                                                   input logic [7:0] sub_id,
                                                   input logic [31:0] value_bits);
        sfbcrc16_pkg::req_t req;
        req.type_id    = type_id;
        req.sub_id     = sub_id;
        req.value_bits = value_bits;
        return req;
    endfunction

    function automatic sfbcrc16_pkg::req_t random_request();
        sfbcrc16_pkg::req_t req;
        req = compose(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom());
        case ($urandom_range(0, 9))
            0:       req.value_bits = '0;
            1:       req.value_bits = '1;
            2:       req.type_id    = '1;
            3:       req.sub_id     = '0;
            default: ;
        endcase
        return req;
    endfunction

    task automatic send_request(input sfbcrc16_pkg::req_t req);
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic idle_for(input int cycles);
        logic [63:0] noise;
        if (cycles > 0)
        begin
            noise    = {$urandom(), $urandom()};
            s_tvalid <= 1'b0;
            s_tdata  <= noise[$bits(s_tdata)-1:0];
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (bytes_due != 0);
    endtask

    initial
    begin : stimulus
        int burst;
        int gap;
        sfbcrc16_pkg::req_t directed [$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        directed.push_back(compose(8'h00, 8'h00, 32'h0000_0000));
        directed.push_back(compose(8'hFF, 8'hFF, 32'hFFFF_FFFF));
        directed.push_back(compose(8'hFF, 8'h00, 32'h0000_0000));
        directed.push_back(compose(8'h00, 8'hFF, 32'hFFFF_FFFF));
        directed.push_back(compose(8'h55, 8'h06, 32'h0155_0655));
        directed.push_back(compose(8'hAA, 8'h55, 32'hAAAA_5555));
        directed.push_back(compose(8'h01, 8'h80, 32'h8000_0001));
        directed.push_back(compose(8'h80, 8'h01, 32'h0000_0080));
        directed.push_back(compose(8'h12, 8'h34, 32'h3F80_0000));
        directed.push_back(compose(8'h7F, 8'hFE, 32'h7F80_0000));
        directed.push_back(compose(8'h0F, 8'hF0, 32'h7FC0_0000));
        directed.push_back(compose(8'hC3, 8'h3C, 32'hBF80_0000));
        for (int i = 0; i < 4; i++)
        begin
            directed.push_back(compose(8'h01 << i, 8'h10 << i, 32'h0000_00FF << (8 * i)));
        end
        foreach (directed[i])
        begin
            send_request(directed[i]);
            directed_sent++;
        end
        wait_drained();

        // Hold the output back while requests keep coming, so the input stalls.
        hold_requests++;
        for (int i = 0; i < 8; i++)
        begin
            send_request(random_request());
            random_sent++;
        end
        wait_drained();

        while (random_sent < RANDOM_REQUESTS)
        begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst && random_sent < RANDOM_REQUESTS; i++)
            begin
                send_request(random_request());
                random_sent++;
            end
            if (random_sent >= RANDOM_REQUESTS / 2 && random_sent - burst < RANDOM_REQUESTS / 2)
            begin
                wait_drained();
            end
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 3);
                2:       gap = $urandom_range(4, 12);
                default: gap = $urandom_range(13, 40);
            endcase
            idle_for(gap);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d directed, %0d random) and checked %0d complete frames.",
                 directed_sent + random_sent, directed_sent, random_sent, frames_done);
        $display("Covered back-to-back requests, random gaps and output stalls, and a %0d-cycle hold-off.",
                 LONG_HOLD);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
